FILE: sv/gpp_pkg.sv
package gpp_pkg;

	localparam int PANEL_WIDTH  = 240;
	localparam int PANEL_HEIGHT = 240;

	localparam int POS_W   = 17;
	localparam int TRIG_W  = 16;
	localparam int SCALE_W = 24;
	localparam int RAD_W   = 14;
	localparam int PIX_W   = 12;
	localparam int TAG_W   = 8;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 3;

	// intermediate widths
	localparam int PROD_W = TRIG_W + POS_W;        // trig * coordinate
	localparam int RX_W   = PROD_W + 1;            // rotated X, Q14
	localparam int MIX_W  = PROD_W + 1;
	localparam int MIXP_W = TRIG_W + MIX_W;        // trig * mix
	localparam int R28_W  = MIXP_W + 1;            // depth and height, Q28
	localparam int RZ_W   = R28_W - 14;            // height, Q14
	localparam int OFF_W  = SCALE_W + 1 + RZ_W;    // offsets, Q38
	localparam int DIFF_W = 64;
	localparam int FRAC_W = 38;
	localparam int Q_W    = DIFF_W - FRAC_W;
	localparam int MAG_W  = OFF_W;
	localparam int RLIM_W = RAD_W + 34;            // radius in Q38
	localparam int SQI_W  = RLIM_W - 18;           // magnitude in Q20
	localparam int SQ_W   = 2 * SQI_W;
	localparam int RR_W   = 2 * RAD_W;
	localparam int SUM_W  = SQ_W + 1;

	localparam logic signed [DIFF_W-1:0] CENTRE_X = DIFF_W'(PANEL_WIDTH) << 37;
	localparam logic signed [DIFF_W-1:0] CENTRE_Y = DIFF_W'(PANEL_HEIGHT) << 37;
	localparam logic signed [Q_W-1:0]    PIX_MAX  = Q_W'(2047);
	localparam logic signed [Q_W-1:0]    PIX_MIN  = -Q_W'(2048);

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_COS_AZ   = 3'd0,
		CFG_SIN_AZ   = 3'd1,
		CFG_COS_TILT = 3'd2,
		CFG_SIN_TILT = 3'd3,
		CFG_SCALE    = 3'd4,
		CFG_RADIUS   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] ca;
		logic signed [TRIG_W-1:0] sa;
		logic signed [TRIG_W-1:0] ct;
		logic signed [TRIG_W-1:0] st;
		logic [SCALE_W-1:0]       scale;
		logic [RAD_W-1:0]         radius;
	} cfg_t;

	typedef struct packed {
		logic signed [RX_W-1:0] rx;
		logic signed [RZ_W-1:0] rz;
		logic                   near;
		logic [TAG_W-1:0]       tag;
		logic                   last;
	} rot_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_x;
		logic signed [PIX_W-1:0] pixel_y;
		logic                    near_side;
		logic                    hidden;
		logic                    on_panel;
		logic [TAG_W-1:0]        tag;
		logic                    last;
	} res_t;

endpackage

FILE: sv/globe_point_projector.sv
// Throughput: one point per cycle while the output does not stall; each of the
// eight stages holds one multiply or one wide add/compare, and stalls back up
// stage by stage. Points with point_valid low are taken and leave no result.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// configuration registers with their reset values.
module globe_point_projector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x[16:0], pos_y[33:17], pos_z[50:34], point_tag[58:51], zero fill
	input  logic [gpp_pkg::S_TDATA_W-1:0]  s_tdata,
	// point_valid[0]
	input  logic [gpp_pkg::S_TUSER_W-1:0]  s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pixel_x[11:0], pixel_y[23:12], tag_out[31:24]
	output logic [gpp_pkg::M_TDATA_W-1:0]  m_tdata,
	// near_side[0], hidden_by_globe[1], on_panel[2]
	output logic [gpp_pkg::M_TUSER_W-1:0]  m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [gpp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gpp_pkg::*;

	cfg_t cfg;
	rot_t rot;
	res_t res;
	logic rot_valid, rot_ready;

	assign cfg_ready = 1'b1;

	gpp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	gpp_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid && s_tuser[0]),
		.in_ready  (s_tready),
		.in_x      (s_tdata[16:0]),
		.in_y      (s_tdata[33:17]),
		.in_z      (s_tdata[50:34]),
		.in_tag    (s_tdata[58:51]),
		.in_last   (s_tlast),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_data  (rot)
	);

	gpp_project u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (rot_valid),
		.in_ready  (rot_ready),
		.in_data   (rot),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = {res.tag, res.pixel_y, res.pixel_x};
	assign m_tuser = {res.on_panel, res.hidden, res.near_side};
	assign m_tlast = res.last;

endmodule

FILE: sv/gpp_cfg.sv
module gpp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [gpp_pkg::CFG_ADDR_W-1:0] wr_addr,
	input  logic [gpp_pkg::CFG_DATA_W-1:0] wr_data,
	output gpp_pkg::cfg_t                   cfg
);
	import gpp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ca     <= TRIG_W'(16384);
			cfg_q.sa     <= '0;
			cfg_q.ct     <= TRIG_W'(16384);
			cfg_q.st     <= '0;
			cfg_q.scale  <= '0;
			cfg_q.radius <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_addr))
				CFG_COS_AZ:   cfg_q.ca     <= wr_data[TRIG_W-1:0];
				CFG_SIN_AZ:   cfg_q.sa     <= wr_data[TRIG_W-1:0];
				CFG_COS_TILT: cfg_q.ct     <= wr_data[TRIG_W-1:0];
				CFG_SIN_TILT: cfg_q.st     <= wr_data[TRIG_W-1:0];
				CFG_SCALE:    cfg_q.scale  <= wr_data[SCALE_W-1:0];
				CFG_RADIUS:   cfg_q.radius <= wr_data[RAD_W-1:0];
				default: ;    // drop writes to unknown indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/gpp_rotate.sv
module gpp_rotate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gpp_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [gpp_pkg::POS_W-1:0] in_x,
	input  logic signed [gpp_pkg::POS_W-1:0] in_y,
	input  logic signed [gpp_pkg::POS_W-1:0] in_z,
	input  logic [gpp_pkg::TAG_W-1:0]        in_tag,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output gpp_pkg::rot_t                     out_data
);
	import gpp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [PROD_W-1:0] cax_s1, say_s1, sax_s1, cay_s1, ctz_s1, stz_s1;
	logic [TAG_W-1:0]         tag_s1, tag_s2, tag_s3;
	logic                     last_s1, last_s2, last_s3;

	logic signed [RX_W-1:0]   rx_s2, rx_s3;
	logic signed [MIX_W-1:0]  mix_s2;
	logic signed [PROD_W-1:0] ctz_s2, stz_s2, ctz_s3, stz_s3;

	logic signed [MIXP_W-1:0] ctm_s3, stm_s3;

	logic signed [R28_W-1:0]  ry28, rz28;
	rot_t                     rot_s4;

	// a stage loads when it is empty or its contents move on
	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cax_s1  <= cfg.ca * in_x;
			say_s1  <= cfg.sa * in_y;
			sax_s1  <= cfg.sa * in_x;
			cay_s1  <= cfg.ca * in_y;
			ctz_s1  <= cfg.ct * in_z;
			stz_s1  <= cfg.st * in_z;
			tag_s1  <= in_tag;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			rx_s2   <= RX_W'(cax_s1) - RX_W'(say_s1);
			mix_s2  <= MIX_W'(sax_s1) + MIX_W'(cay_s1);
			ctz_s2  <= ctz_s1;
			stz_s2  <= stz_s1;
			tag_s2  <= tag_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			ctm_s3  <= cfg.ct * mix_s2;
			stm_s3  <= cfg.st * mix_s2;
			rx_s3   <= rx_s2;
			ctz_s3  <= ctz_s2;
			stz_s3  <= stz_s2;
			tag_s3  <= tag_s2;
			last_s3 <= last_s2;
		end
	end

	assign ry28 = R28_W'(ctm_s3) - (R28_W'(stz_s3) <<< 14);
	assign rz28 = R28_W'(stm_s3) + (R28_W'(ctz_s3) <<< 14);

	always_ff @(posedge clk) begin
		if (en4) begin
			rot_s4.rx   <= rx_s3;
			// dropping the low bits rounds toward minus infinity
			rot_s4.rz   <= rz28[R28_W-1:14];
			rot_s4.near <= !ry28[R28_W-1];
			rot_s4.tag  <= tag_s3;
			rot_s4.last <= last_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = rot_s4;

endmodule

FILE: sv/gpp_project.sv
module gpp_project (
	input  logic          clk,
	input  logic          arst_n,
	input  gpp_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  gpp_pkg::rot_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output gpp_pkg::res_t out_data
);
	import gpp_pkg::*;

	function automatic logic signed [PIX_W-1:0] to_pixel(
		input logic signed [DIFF_W-1:0] diff
	);
		logic signed [Q_W-1:0] q;
		q = diff[DIFF_W-1:FRAC_W];
		// shift floors; step back up to truncate toward zero
		if (diff[DIFF_W-1] && (diff[FRAC_W-1:0] != '0))
			q = q + Q_W'(1);
		if (q < PIX_MIN)
			return PIX_W'(PIX_MIN);
		if (q > PIX_MAX)
			return PIX_W'(PIX_MAX);
		return q[PIX_W-1:0];
	endfunction

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [OFF_W-1:0] v);
		logic signed [OFF_W-1:0] n;
		n = -v;
		return v[OFF_W-1] ? MAG_W'(n) : MAG_W'(v);
	endfunction

	logic v_s5, v_s6, v_s7, v_s8;
	logic en5, en6, en7, en8;

	logic signed [OFF_W-1:0] offx_s5, offz_s5;
	logic                    near_s5, near_s6, near_s7;
	logic [TAG_W-1:0]        tag_s5, tag_s6, tag_s7;
	logic                    last_s5, last_s6, last_s7;

	logic signed [PIX_W-1:0] px_s6, py_s6, px_s7, py_s7;
	logic                    inside_s6, inside_s7;
	logic [SQI_W-1:0]        a_s6, b_s6;

	logic [SQ_W-1:0]         sqa_s7, sqb_s7;
	logic                    onp_s7;

	res_t                    res_s8;

	logic [MAG_W-1:0]        ax, az;
	logic [RLIM_W-1:0]       rlim;
	logic [RR_W-1:0]         rr;
	logic [SUM_W-1:0]        sq_sum, rsq;

	assign en8 = !v_s8 || out_ready;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign in_ready = en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en5) v_s5 <= in_valid;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			offx_s5 <= $signed({1'b0, cfg.scale}) * in_data.rx;
			offz_s5 <= $signed({1'b0, cfg.scale}) * in_data.rz;
			near_s5 <= in_data.near;
			tag_s5  <= in_data.tag;
			last_s5 <= in_data.last;
		end
	end

	assign ax   = magnitude(offx_s5);
	assign az   = magnitude(offz_s5);
	assign rlim = {cfg.radius, 34'b0};

	always_ff @(posedge clk) begin
		if (en6) begin
			px_s6     <= to_pixel(CENTRE_X - DIFF_W'(offx_s5));
			py_s6     <= to_pixel(CENTRE_Y - DIFF_W'(offz_s5));
			// at or beyond the radius on either axis is outside the disc
			inside_s6 <= (ax < MAG_W'(rlim)) && (az < MAG_W'(rlim));
			a_s6      <= ax[RLIM_W-1:18];
			b_s6      <= az[RLIM_W-1:18];
			near_s6   <= near_s5;
			tag_s6    <= tag_s5;
			last_s6   <= last_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			sqa_s7    <= a_s6 * a_s6;
			sqb_s7    <= b_s6 * b_s6;
			px_s7     <= px_s6;
			py_s7     <= py_s6;
			onp_s7    <= !px_s6[PIX_W-1] && ($unsigned(px_s6) < PIX_W'(PANEL_WIDTH))
				&& !py_s6[PIX_W-1] && ($unsigned(py_s6) < PIX_W'(PANEL_HEIGHT));
			inside_s7 <= inside_s6;
			near_s7   <= near_s6;
			tag_s7    <= tag_s6;
			last_s7   <= last_s6;
		end
	end

	assign rr     = cfg.radius * cfg.radius;
	assign rsq    = SUM_W'({rr, 32'b0});
	assign sq_sum = SUM_W'(sqa_s7) + SUM_W'(sqb_s7);

	always_ff @(posedge clk) begin
		if (en8) begin
			res_s8.pixel_x   <= px_s7;
			res_s8.pixel_y   <= py_s7;
			res_s8.near_side <= near_s7;
			res_s8.hidden    <= !near_s7 && inside_s7 && (sq_sum < rsq);
			res_s8.on_panel  <= onp_s7;
			res_s8.tag       <= tag_s7;
			res_s8.last      <= last_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_data  = res_s8;

endmodule

FILE: sv/gpp_checker.sv
module gpp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [gpp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [gpp_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                           m_tlast
);
	import gpp_pkg::*;

	// a stalled result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// the input side backs up only when the output stalls
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output free");

	a_hidden_far: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("near-side point flagged hidden");

	a_on_panel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tdata[11] && (m_tdata[10:0] < 11'(PANEL_WIDTH))
			&& !m_tdata[23] && (m_tdata[22:12] < 11'(PANEL_HEIGHT)))
		else $error("on-panel flag with pixel off the panel");

endmodule

bind globe_point_projector gpp_checker u_gpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: tb/globe_point_projector_test.sv
`timescale 1ns / 1ps

module globe_point_projector_test;
	import gpp_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int PIPE_LATENCY  = 8;
	localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY;
	localparam int BATCH_POINTS  = 250;
	localparam int NUM_SETTINGS  = 8;
	localparam int LONG_HOLD     = 80;
	localparam int MAX_REPORTS   = 10;

	// register indexes that decode to nothing
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd7;

	localparam longint Q38_ONE = longint'(1) <<< 38;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic                    valid;
		logic [TAG_W-1:0]        tag;
		logic                    last;
	} point_t;

	typedef struct packed {
		logic [CFG_ADDR_W-1:0] addr;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic [S_TUSER_W-1:0]  s_tuser  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	globe_point_projector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	point_t     pending_points[$];
	reg_write_t pending_writes[$];
	res_t       expected_pixels[$];
	cfg_t       camera;

	int  snd_idle_pct = 36;
	int  rcv_idle_pct = 88;
	int  hold_requests = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	logic in_held = 1'b0;

	int  cycles = 0;
	int  mismatches = 0;
	int  points_taken = 0;
	int  results_checked = 0;
	int  settings_run = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat_pixel(longint diff_q38);
		longint p;
		p = diff_q38 / Q38_ONE;
		if (p < -2048)
			p = -2048;
		if (p > 2047)
			p = 2047;
		return p;
	endfunction

	function automatic res_t project_point(point_t p, cfg_t c);
		longint x, y, z, ca, sa, ct, st, sc;
		longint rx, mix, depth, rz_q28, rz, offx, offz, px, py;
		u64_t   r_q38, ax, az, a, b, r;
		res_t   res;
		x  = longint'(p.pos_x);
		y  = longint'(p.pos_y);
		z  = longint'(p.pos_z);
		ca = longint'(c.ca);
		sa = longint'(c.sa);
		ct = longint'(c.ct);
		st = longint'(c.st);
		sc = longint'(c.scale);
		rx     = ca * x - sa * y;
		mix    = sa * x + ca * y;
		depth  = ct * mix - st * z * 16384;
		rz_q28 = st * mix + ct * z * 16384;
		rz     = rz_q28 >>> 14;
		offx   = sc * rx;
		offz   = sc * rz;
		px = sat_pixel((longint'(PANEL_WIDTH) <<< 37) - offx);
		py = sat_pixel((longint'(PANEL_HEIGHT) <<< 37) - offz);
		res.pixel_x   = px[PIX_W-1:0];
		res.pixel_y   = py[PIX_W-1:0];
		res.near_side = (depth >= 0);
		res.hidden    = 1'b0;
		if (depth < 0) begin
			// anything at or past the radius on either axis is outside the disc
			r_q38 = u64_t'(c.radius) << 34;
			ax = (offx < 0) ? u64_t'(-offx) : u64_t'(offx);
			az = (offz < 0) ? u64_t'(-offz) : u64_t'(offz);
			if (ax < r_q38 && az < r_q38) begin
				a = ax >> 18;
				b = az >> 18;
				r = u64_t'(c.radius) << 16;
				res.hidden = (a * a + b * b) < (r * r);
			end
		end
		res.on_panel = (px >= 0) && (px < PANEL_WIDTH) && (py >= 0) && (py < PANEL_HEIGHT);
		res.tag  = p.tag;
		res.last = p.last;
		return res;
	endfunction

	// sender: hold an offered transaction until taken, else maybe idle
	always @(negedge clk) begin
		if (!in_held) begin
			if (pending_points.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= S_TDATA_W'({pending_points[0].tag, pending_points[0].pos_z,
				                        pending_points[0].pos_y, pending_points[0].pos_x});
				s_tuser  <= pending_points[0].valid;
				s_tlast  <= pending_points[0].last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: a requested long hold-off wins over random idling
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_served + 1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	always @(negedge clk) begin
		cfg_valid <= (pending_writes.size() != 0);
		if (pending_writes.size() != 0) begin
			cfg_addr <= pending_writes[0].addr;
			cfg_data <= pending_writes[0].data;
		end
	end

	always @(posedge clk) begin : monitor
		point_t p;
		res_t   got;
		res_t   want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
			         expected_pixels.size());
			$display("** globe_point_projector: FAILED **");
			$finish;
		end
		in_held <= s_tvalid && !s_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					CFG_COS_AZ:   camera.ca     = cfg_data[TRIG_W-1:0];
					CFG_SIN_AZ:   camera.sa     = cfg_data[TRIG_W-1:0];
					CFG_COS_TILT: camera.ct     = cfg_data[TRIG_W-1:0];
					CFG_SIN_TILT: camera.st     = cfg_data[TRIG_W-1:0];
					CFG_SCALE:    camera.scale  = cfg_data[SCALE_W-1:0];
					CFG_RADIUS:   camera.radius = cfg_data[RAD_W-1:0];
					default: ;
				endcase
				void'(pending_writes.pop_front());
			end
			if (s_tvalid && s_tready) begin
				p = pending_points.pop_front();
				points_taken++;
				if (p.valid)
					expected_pixels.push_back(project_point(p, camera));
			end
			if (m_tvalid && m_tready) begin
				got.pixel_x   = m_tdata[11:0];
				got.pixel_y   = m_tdata[23:12];
				got.tag       = m_tdata[31:24];
				got.near_side = m_tuser[0];
				got.hidden    = m_tuser[1];
				got.on_panel  = m_tuser[2];
				got.last      = m_tlast;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result at cycle %0d: px %0d py %0d tag %0d",
						         cycles, got.pixel_x, got.pixel_y, got.tag);
				end else begin
					want = expected_pixels.pop_front();
					results_checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("mismatch at cycle %0d: exp px %0d py %0d near %b hid %b on %b tag %0d last %b",
							         cycles, want.pixel_x, want.pixel_y, want.near_side,
							         want.hidden, want.on_panel, want.tag, want.last);
							$display("    got px %0d py %0d near %b hid %b on %b tag %0d last %b",
							         got.pixel_x, got.pixel_y, got.near_side, got.hidden,
							         got.on_panel, got.tag, got.last);
						end
					end
				end
			end
		end
	end

	task automatic add_point(int x, int y, int z, bit v, int tag, bit last);
		point_t p;
		p.pos_x = POS_W'(x);
		p.pos_y = POS_W'(y);
		p.pos_z = POS_W'(z);
		p.valid = v;
		p.tag   = TAG_W'(tag);
		p.last  = last;
		pending_points.push_back(p);
	endtask

	function automatic int rand_coord(int mode);
		case (mode)
			0: return int'($urandom_range(0, 16000)) - 8000;
			1: return int'($urandom_range(0, 131071)) - 65536;
			default: begin
				case ($urandom_range(0, 4))
					0: return -65536;
					1: return 65535;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	task automatic add_random_point();
		int roll;
		int mode;
		roll = $urandom_range(0, 99);
		mode = (roll < 70) ? 0 : ((roll < 88) ? 1 : 2);
		add_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
		          $urandom_range(0, 9) != 0, $urandom_range(0, 255),
		          $urandom_range(0, 7) == 0);
	endtask

	task automatic queue_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		reg_write_t w;
		w.addr = addr;
		w.data = data;
		pending_writes.push_back(w);
	endtask

	// only called with the pipeline empty
	task automatic apply_setting(logic signed [TRIG_W-1:0] ca, logic signed [TRIG_W-1:0] sa,
	                             logic signed [TRIG_W-1:0] ct, logic signed [TRIG_W-1:0] st,
	                             logic [SCALE_W-1:0] scale, logic [RAD_W-1:0] radius);
		queue_write(CFG_COS_AZ, CFG_DATA_W'(ca));
		queue_write(CFG_SIN_AZ, CFG_DATA_W'(sa));
		queue_write(CFG_COS_TILT, CFG_DATA_W'(ct));
		queue_write(CFG_SIN_TILT, CFG_DATA_W'(st));
		queue_write(CFG_SCALE, scale);
		queue_write(CFG_RADIUS, CFG_DATA_W'(radius));
		while (pending_writes.size() != 0)
			@(posedge clk);
		@(posedge clk);
		settings_run++;
	endtask

	task automatic drain();
		while (pending_points.size() != 0 || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [TRIG_W-1:0] to_q14(real v);
		int t;
		t = $rtoi(v * 16384.0);
		return TRIG_W'(t);
	endfunction

	initial begin : stimulus
		real az;
		real tilt;
		logic signed [TRIG_W-1:0] ca, sa, ct, st;
		logic [SCALE_W-1:0] scale;
		logic [RAD_W-1:0]   radius;
		int n;
		camera.ca     = 16'sd16384;
		camera.sa     = '0;
		camera.ct     = 16'sd16384;
		camera.st     = '0;
		camera.scale  = '0;
		camera.radius = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset registers: every point lands on the panel centre
		add_point(0, 0, 0, 1, 0, 0);
		add_point(65535, -65536, 65535, 1, 255, 1);
		add_point(-65536, 65535, -65536, 1, 170, 0);
		drain();

		// straight-on camera, globe of 100 px radius
		apply_setting(16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 24'd263000, 14'd1600);
		queue_write(CFG_SPARE_A, 24'hFFFFFF);
		queue_write(CFG_SPARE_B, 24'h5A5A5A);
		while (pending_writes.size() != 0)
			@(posedge clk);
		add_point(0, -5000, 0, 1, 1, 0);         // behind the globe, inside the disc
		add_point(0, 5000, 0, 1, 2, 0);          // facing the camera
		add_point(0, 0, 0, 1, 3, 0);             // zero depth counts as near
		add_point(6000, -100, 6000, 1, 4, 0);    // behind but outside the disc
		add_point(-65536, -65536, -65536, 1, 5, 0);
		add_point(65535, 65535, 65535, 1, 6, 1);
		add_point(100, -1, 100, 0, 255, 1);      // dropped, no result
		add_point(100, -1, 100, 1, 0, 1);
		drain();

		// extreme trig, full scale and radius: some pixels saturate
		apply_setting(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 24'hFFFFFF, 14'h3FFF);
		add_point(65535, -65536, 65535, 1, 7, 0);
		add_point(-65536, 65535, -65536, 1, 8, 0);
		add_point(1, 0, 0, 1, 9, 0);
		add_point(0, 0, 1, 1, 10, 0);
		add_point(0, -1, 0, 1, 11, 0);
		add_point(-1, -1, -1, 1, 12, 1);
		drain();

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			az   = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
			tilt = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
			ca = to_q14($cos(az));
			sa = to_q14($sin(az));
			ct = to_q14($cos(tilt));
			st = to_q14($sin(tilt));
			scale  = SCALE_W'($urandom_range(100000, 600000));
			radius = RAD_W'($urandom_range(800, 3200));
			case (s)
				1: begin
					ca = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
					st = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
					sa = 16'sd0;
					ct = 16'sd0;
					scale  = 24'hFFFFFF;
					radius = 14'h3FFF;
				end
				2: begin
					scale  = '0;
					radius = '0;
				end
				4: begin
					// raw patterns outside the unit range
					ca = TRIG_W'($urandom());
					sa = TRIG_W'($urandom());
					ct = TRIG_W'($urandom());
					st = TRIG_W'($urandom());
					scale  = SCALE_W'($urandom());
					radius = RAD_W'($urandom());
				end
				6: begin
					ca = 16'sh7FFF;
					sa = 16'sh8000;
					ct = 16'sh8000;
					st = 16'sh7FFF;
				end
				default: ;
			endcase
			if (s < 3) begin
				snd_idle_pct = 36;
				rcv_idle_pct = 88;
			end else if (s < 6) begin
				snd_idle_pct = 88;
				rcv_idle_pct = 36;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			apply_setting(ca, sa, ct, st, scale, radius);
			n = 0;
			while (n < BATCH_POINTS) begin
				add_random_point();
				n++;
				// pause the sender until the pipeline has emptied
				if (s == 7 && n == BATCH_POINTS / 2) begin
					while (pending_points.size() != 0 || expected_pixels.size() != 0)
						@(posedge clk);
				end
			end
			// receiver backs off while the sender keeps offering
			if (s == 6)
				hold_requests = hold_requests + 1;
			drain();
		end

		$display("Checked %0d results from %0d points over %0d register settings.",
		         results_checked, points_taken, settings_run);
		$display("Included saturation, occlusion, dropped points and a long output stall.");
		if (mismatches == 0) begin
			$display("** globe_point_projector: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** globe_point_projector: FAILED **");
		end
		$finish;
	end

endmodule
